// ===== src/hpg_pkg.sv =====
// Shared types, codes and helper functions of the hotplug load governor.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hpg_pkg;

  localparam int CORE_COUNT = 8;
  localparam logic [7:0] ALL_CORES = 8'((1 << CORE_COUNT) - 1);

  localparam logic [6:0] LOAD_SCALE    = 7'd100;
  localparam logic [6:0] THRESHOLD_MIN = 7'd11;
  localparam logic [6:0] THRESHOLD_RST = 7'd65;
  localparam logic [3:0] SUSPEND_MIN   = 4'd1;
  localparam logic [3:0] SUSPEND_MAX   = 4'd8;
  localparam logic [3:0] SUSPEND_RST   = 4'd2;

  // input func codes
  localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
  localparam logic [1:0] FUNC_SUSPEND = 2'd1;
  localparam logic [1:0] FUNC_RESUME  = 2'd2;

  // classified operations
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_SKIP    = 2'd1;
  localparam logic [1:0] OP_SUSPEND = 2'd2;
  localparam logic [1:0] OP_RESUME  = 2'd3;

  // result actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_UP   = 2'd1;
  localparam logic [1:0] ACT_DOWN = 2'd2;

  // endurance levels
  localparam logic [1:0] LEVEL_FULL = 2'd0;
  localparam logic [1:0] LEVEL_FOUR = 2'd1;
  localparam logic [1:0] LEVEL_TWO  = 2'd2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_SUSPEND   = 2'd1;
  localparam logic [1:0] REG_ENDURANCE = 2'd2;

  typedef struct packed {
    logic [6:0] threshold;
    logic [3:0] suspend_cores;
    logic [1:0] level;
  } cfg_t;

  // only the low 32 bits of the counters ever reach a delta
  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  core;
    logic [31:0] wall;
    logic [31:0] idle;
  } entry_t;

  function automatic logic [3:0] level_cap(input logic [1:0] level);
    logic [3:0] lim;
    case (level)
      LEVEL_FOUR: lim = 4'd4;
      LEVEL_TWO:  lim = 4'd2;
      default:    lim = 4'd8;
    endcase
    if (lim > 4'(CORE_COUNT)) lim = 4'(CORE_COUNT);
    return lim;
  endfunction

  // cores that stay online on suspend
  function automatic logic [7:0] suspend_keep(input logic [1:0] level,
                                              input logic [3:0] cores);
    logic [3:0] n;
    logic [7:0] keep;
    n = cores;
    if (level == LEVEL_FOUR && n > 4'd4) n = 4'd4;
    if (level == LEVEL_TWO && n > 2'd2) n = 4'd2;
    if (n < SUSPEND_MIN) n = SUSPEND_MIN;
    for (int c = 0; c < 8; c++) keep[c] = (4'(c) < n);
    return keep;
  endfunction

  // cores brought online on resume
  function automatic logic [7:0] resume_set(input logic [1:0] level);
    logic [3:0] r;
    logic [7:0] set;
    case (level)
      LEVEL_FOUR: r = 4'd3;
      LEVEL_TWO:  r = 4'd1;
      default:    r = 4'd7;
    endcase
    for (int c = 0; c < 8; c++) set[c] = (c >= 1) && (4'(c) <= r) && (c < CORE_COUNT);
    return set;
  endfunction

endpackage

`default_nettype wire

// ===== src/cpu_hotplug_load_governor_top.sv =====
// Hotplug load governor for up to eight cores: registers, front end, queue
// and back end. Depends on hpg_pkg, hpg_front, hpg_queue and hpg_back.
//
// Each input request (func in s_tuser) gives exactly one result on the
// m_ stream. A core load sample runs the seven-step restoring divider that
// forms 100*(wall-idle)/wall in the back end when the core was online at
// tick start and the wall delta is usable. A sample for a core offline at
// tick start, one with a zero wall delta or idle above wall, and suspend,
// resume, unused and out-of-limit requests skip the divider. The result is
// registered onto m_ when the back end finishes, later if the previous
// result still waits on m_tready. The front end takes one request per cycle
// into a two-entry queue, so input stays open while the back end works
// until the queue fills.
// Registers (APB, byte address 4*index): threshold at 0, suspend core count
// at 4, endurance level at 8; out-of-range writes are dropped.
`timescale 1ns / 1ps
`default_nettype none

module cpu_hotplug_load_governor_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [135:0] s_tdata,   // core_index[2:0], wall_total[66:3],
                                       // idle_total[130:67], zero pad
  input  wire logic [1:0]   s_tuser,   // func
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [31:0]       m_tdata,   // target_core[2:0], online_mask[10:3],
                                       // core_load[17:11], average_load[24:18]
  output logic [1:0]        m_tuser,   // action
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import hpg_pkg::*;

  cfg_t   cfg;
  logic   q_push;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;
  entry_t q_in;
  entry_t q_out;
  logic   wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold     <= THRESHOLD_RST;
      cfg.suspend_cores <= SUSPEND_RST;
      cfg.level         <= LEVEL_FULL;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_THRESHOLD: begin
          if (pwdata[6:0] >= THRESHOLD_MIN) cfg.threshold <= pwdata[6:0];
        end
        REG_SUSPEND: begin
          if (pwdata[3:0] >= SUSPEND_MIN && pwdata[3:0] <= SUSPEND_MAX)
            cfg.suspend_cores <= pwdata[3:0];
        end
        REG_ENDURANCE: begin
          if (pwdata[1:0] <= LEVEL_TWO) cfg.level <= pwdata[1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_THRESHOLD: prdata = {25'd0, cfg.threshold};
      REG_SUSPEND:   prdata = {28'd0, cfg.suspend_cores};
      REG_ENDURANCE: prdata = {30'd0, cfg.level};
      default:       prdata = 32'd0;
    endcase
  end

  hpg_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  hpg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .entry_in  (q_in),
    .full      (q_full),
    .valid     (q_valid),
    .pop       (q_pop),
    .entry_out (q_out)
  );

  hpg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_entry  (q_out),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_mask_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[10:3] & ~ALL_CORES) == 8'd0)
    else $error("online mask has a core beyond the core count");

  a_target_matches_action: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == ACT_NONE) == (m_tdata[2:0] == 3'd0)))
    else $error("target core does not match action");

  a_load_bounds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[17:11] <= LOAD_SCALE && m_tdata[24:18] <= LOAD_SCALE))
    else $error("load percent above 100");

endmodule

`default_nettype wire

// ===== src/hpg_front.sv =====
// Front end: accepts requests from the input stream and classifies them.
// Depends on hpg_pkg; feeds hpg_queue.
`timescale 1ns / 1ps
`default_nettype none

module hpg_front (
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [135:0]    s_tdata,   // core_index, wall_total, idle_total, pad
  input  wire logic [1:0]      s_tuser,   // func
  input  wire hpg_pkg::cfg_t   cfg,
  input  wire logic            q_full,
  output logic                 q_push,
  output hpg_pkg::entry_t      q_entry
);
  import hpg_pkg::*;

  logic [2:0] core;
  logic       in_range;

  assign core     = s_tdata[2:0];
  assign in_range = {1'b0, core} < level_cap(cfg.level);

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_entry.core = core;
    q_entry.wall = s_tdata[34:3];
    q_entry.idle = s_tdata[98:67];
    case (s_tuser)
      FUNC_SAMPLE:  q_entry.op = in_range ? OP_SAMPLE : OP_SKIP;
      FUNC_SUSPEND: q_entry.op = OP_SUSPEND;
      FUNC_RESUME:  q_entry.op = OP_RESUME;
      default:      q_entry.op = OP_SKIP;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/hpg_queue.sv =====
// Two-entry queue between the classifying front end and the back end.
// Depends on hpg_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module hpg_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire hpg_pkg::entry_t entry_in,
  output logic                 full,
  output logic                 valid,
  input  wire logic            pop,
  output hpg_pkg::entry_t      entry_out
);
  import hpg_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign valid     = count != 2'd0;
  assign entry_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= entry_in;
  end

endmodule

`default_nettype wire

// ===== src/hpg_back.sv =====
// Back end: keeps the per-core counters and online state, computes the load
// with a restoring divider and decides hotplug actions. Depends on hpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpg_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire hpg_pkg::cfg_t   cfg,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire hpg_pkg::entry_t q_entry,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [31:0]          m_tdata,   // target_core, online_mask, core_load,
                                          // average_load, pad
  output logic [1:0]           m_tuser    // action
);
  import hpg_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_DECIDE = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0]  state;
  entry_t      cur;
  logic [7:0]  online;
  logic [7:0]  tick_start;
  logic [31:0] prev_wall [8];
  logic [31:0] prev_idle [8];
  logic [6:0]  prev_load [8];

  logic [31:0] wall_q;
  logic [31:0] idle_q;
  logic [31:0] diff;
  logic [38:0] rem;
  logic [6:0]  quo;
  logic [2:0]  step;

  logic [1:0]  res_action;
  logic [2:0]  res_target;
  logic [6:0]  res_load;
  logic [6:0]  res_avg;

  logic [1:0]  out_action;
  logic [2:0]  out_target;
  logic [7:0]  out_mask;
  logic [6:0]  out_load;
  logic [6:0]  out_avg;

  logic [7:0]  tick_bits;
  logic [38:0] shifted;
  logic [7:0]  avg_sum;
  logic [6:0]  avg;
  logic [3:0]  nxt;
  logic        nxt_on;
  logic        out_load_en;

  assign q_pop       = (state == ST_IDLE) && q_valid;
  assign tick_bits   = (cur.core == 3'd0) ? online : tick_start;
  assign shifted     = 39'(wall_q) << step;
  assign avg_sum     = {1'b0, quo} + {1'b0, prev_load[cur.core]};
  assign avg         = avg_sum[7:1];
  assign nxt         = {1'b0, cur.core} + 4'd1;
  assign nxt_on      = online[nxt[2:0]];
  assign out_load_en = (state == ST_OUT) && (!m_tvalid || m_tready);

  assign m_tuser = out_action;
  assign m_tdata = {7'd0, out_avg, out_load, out_mask, out_target};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      online     <= ALL_CORES;
      tick_start <= ALL_CORES;
      m_tvalid   <= 1'b0;
      for (int c = 0; c < 8; c++) begin
        prev_wall[c] <= '0;
        prev_idle[c] <= '0;
        prev_load[c] <= '0;
      end
    end else begin
      if (out_load_en) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (q_valid) state <= ST_EXEC;
        end
        ST_EXEC: begin
          case (cur.op)
            OP_SAMPLE: begin
              if (cur.core == 3'd0) tick_start <= online;
              if (tick_bits[cur.core]) begin
                prev_wall[cur.core] <= cur.wall;
                prev_idle[cur.core] <= cur.idle;
                state <= ST_CHECK;
              end else begin
                state <= ST_DECIDE;
              end
            end
            OP_SUSPEND: begin
              online <= online & suspend_keep(cfg.level, cfg.suspend_cores) & ALL_CORES;
              state  <= ST_OUT;
            end
            OP_RESUME: begin
              online <= (online | resume_set(cfg.level)) & ALL_CORES;
              state  <= ST_OUT;
            end
            default: state <= ST_OUT;
          endcase
        end
        ST_CHECK: begin
          if (wall_q == 32'd0 || wall_q < idle_q) state <= ST_DECIDE;
          else state <= ST_MUL;
        end
        ST_MUL: state <= ST_DIV;
        ST_DIV: begin
          if (step == 3'd0) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          prev_load[cur.core] <= quo;
          if (online[cur.core] && nxt < 4'(CORE_COUNT)) begin
            if (avg > cfg.threshold && !nxt_on) online[nxt[2:0]] <= 1'b1;
            else if (avg < cfg.threshold && nxt_on) online[nxt[2:0]] <= 1'b0;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load_en) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_entry;
    case (state)
      ST_EXEC: begin
        wall_q     <= cur.wall - prev_wall[cur.core];
        idle_q     <= cur.idle - prev_idle[cur.core];
        quo        <= '0;
        res_action <= ACT_NONE;
        res_target <= '0;
        res_load   <= '0;
        res_avg    <= '0;
      end
      ST_CHECK: diff <= wall_q - idle_q;
      ST_MUL: begin
        // 100 * diff as shifts and adds
        rem  <= {1'b0, diff, 6'd0} + {2'b0, diff, 5'd0} + {5'b0, diff, 2'd0};
        quo  <= '0;
        step <= 3'd6;
      end
      ST_DIV: begin
        if (rem >= shifted) begin
          rem       <= rem - shifted;
          quo[step] <= 1'b1;
        end
        step <= step - 3'd1;
      end
      ST_DECIDE: begin
        res_load   <= quo;
        res_avg    <= avg;
        res_action <= ACT_NONE;
        res_target <= '0;
        if (online[cur.core] && nxt < 4'(CORE_COUNT)) begin
          if (avg > cfg.threshold && !nxt_on) begin
            res_action <= ACT_UP;
            res_target <= nxt[2:0];
          end else if (avg < cfg.threshold && nxt_on) begin
            res_action <= ACT_DOWN;
            res_target <= nxt[2:0];
          end
        end
      end
      default: ;
    endcase
    if (out_load_en) begin
      out_action <= res_action;
      out_target <= res_target;
      out_mask   <= online;
      out_load   <= res_load;
      out_avg    <= res_avg;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the hotplug load governor: directed and random requests on
// the s_ stream, results checked on the m_ stream against a built-in predictor.
// Depends on hpg_pkg and cpu_hotplug_load_governor_top.
`timescale 1ns / 1ps

module tb;
  import hpg_pkg::*;

  localparam logic [1:0] FUNC_UNUSED   = 2'd3;
  localparam logic [1:0] LEVEL_INVALID = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 68;
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] target;
    logic [7:0] mask;
    logic [6:0] load;
    logic [6:0] avg;
  } result_t;

  class governor_scoreboard;
    logic [6:0]  threshold;
    logic [3:0]  suspend_cores;
    logic [1:0]  level;
    logic [7:0]  online;
    logic [7:0]  tick_start;
    logic [63:0] last_wall[8];
    logic [63:0] last_idle[8];
    logic [6:0]  prev_pct[8];
    result_t     pending[$];
    int          errors;

    function new();
      threshold = THRESHOLD_RST;
      suspend_cores = SUSPEND_RST;
      level = LEVEL_FULL;
      online = ALL_CORES;
      tick_start = ALL_CORES;
      for (int c = 0; c < 8; c++) begin
        last_wall[c] = '0;
        last_idle[c] = '0;
        prev_pct[c] = '0;
      end
      errors = 0;
    endfunction

    function int active_cores();
      int lim;
      lim = (level == LEVEL_FOUR) ? 4 : (level == LEVEL_TWO) ? 2 : 8;
      if (lim > CORE_COUNT) lim = CORE_COUNT;
      return lim;
    endfunction

    // out-of-range values leave the register as it was
    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_THRESHOLD: if (value[6:0] >= THRESHOLD_MIN) threshold = value[6:0];
        REG_SUSPEND: begin
          if (value[3:0] >= SUSPEND_MIN && value[3:0] <= SUSPEND_MAX)
            suspend_cores = value[3:0];
        end
        REG_ENDURANCE: if (value[1:0] <= LEVEL_TWO) level = value[1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [1:0] func, logic [2:0] core,
                               logic [63:0] wall, logic [63:0] idle);
      result_t r;
      logic [31:0] dw, di;
      logic [7:0] sum;
      int keep, top;
      r = '0;
      if (func == FUNC_SAMPLE) begin
        if (int'(core) < active_cores()) begin
          if (core == 3'd0) tick_start = online;
          if (tick_start[core]) begin
            dw = 32'(wall - last_wall[core]);
            di = 32'(idle - last_idle[core]);
            last_wall[core] = wall;
            last_idle[core] = idle;
            if (dw != 0 && dw >= di) r.load = 7'((64'd100 * 64'(dw - di)) / 64'(dw));
          end
          sum = 8'(r.load) + 8'(prev_pct[core]);
          r.avg = sum[7:1];
          prev_pct[core] = r.load;
          if (online[core] && int'(core) + 1 < CORE_COUNT) begin
            if (r.avg > threshold && !online[core + 1]) begin
              online[core + 1] = 1'b1;
              r.action = ACT_UP;
              r.target = core + 3'd1;
            end else if (r.avg < threshold && online[core + 1]) begin
              online[core + 1] = 1'b0;
              r.action = ACT_DOWN;
              r.target = core + 3'd1;
            end
          end
        end
      end else if (func == FUNC_SUSPEND) begin
        // clamp by endurance level, never stored back
        keep = int'(suspend_cores);
        if (level == LEVEL_FOUR && keep > 4) keep = 4;
        if (level == LEVEL_TWO && keep > 2) keep = 2;
        if (keep < 1) keep = 1;
        for (int c = keep; c < CORE_COUNT; c++) online[c] = 1'b0;
      end else if (func == FUNC_RESUME) begin
        top = (level == LEVEL_FOUR) ? 3 : (level == LEVEL_TWO) ? 1 : 7;
        for (int c = 1; c <= top && c < CORE_COUNT; c++) online[c] = 1'b1;
      end
      r.mask = online;
      pending.push_back(r);
    endfunction

    function void compare(string field, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h with nothing outstanding", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare("action", want.action, got.action);
      compare("target_core", want.target, got.target);
      compare("online_mask", want.mask, got.mask);
      compare("core_load", want.load, got.load);
      compare("average_load", want.avg, got.avg);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;  // core_index, wall_total, idle_total, zero pad
  logic [1:0]   s_tuser = '0;  // func
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;       // target_core, online_mask, core_load, average_load
  logic [1:0]   m_tuser;       // action
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  governor_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int items_sent = 0;
  logic [63:0] run_wall[8];
  logic [63:0] run_idle[8];

  cpu_hotplug_load_governor_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // receiver; a long hold-off is asked for by bumping hold_requests
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result({m_tuser, m_tdata[2:0], m_tdata[10:3], m_tdata[17:11], m_tdata[24:18]});
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else if (!rst)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] func, logic [2:0] core,
                              logic [63:0] wall, logic [63:0] idle);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {5'd0, idle, wall, core};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(func, core, wall, idle);
    items_sent++;
  endtask

  task automatic idle_input();
    s_tvalid <= 1'b0;
  endtask

  // wait until every outstanding request has its result
  task automatic drain();
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  // penable is lowered by the next setup cycle or by apb_release
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic apb_release();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(int thr, int susp, logic [1:0] lvl);
    write_reg(REG_THRESHOLD, 32'(thr));
    write_reg(REG_SUSPEND, 32'(susp));
    write_reg(REG_ENDURANCE, 32'(lvl));
    // one out-of-range write that must be dropped
    case ($urandom_range(2))
      0: write_reg(REG_THRESHOLD, 32'($urandom_range(10)));
      1: write_reg(REG_SUSPEND, ($urandom_range(1) == 0) ? 32'd0 : 32'($urandom_range(15, 9)));
      default: write_reg(REG_ENDURANCE, 32'(LEVEL_INVALID));
    endcase
    apb_release();
  endtask

  task automatic send_sample(logic [2:0] core, int pct);
    logic [63:0] d, busy;
    int pick;
    pick = $urandom_range(63);
    if (pick < 2) d = '0;
    else if (pick < 6) d = {32'd0, $urandom};
    else d = 64'($urandom_range(100000, 1000));
    busy = d * 64'(pct) / 64'd100;
    run_wall[core] += d;
    if (pick == 6) run_idle[core] += d + 64'($urandom_range(5000, 1));  // idle beyond wall
    else run_idle[core] += d - busy;
    send_request(FUNC_SAMPLE, core, run_wall[core], run_idle[core]);
  endtask

  // one well-formed tick: cores 0..limit-1 in order with a shared load profile
  task automatic run_tick();
    int lim, style, pct;
    lim = sb.active_cores();
    style = $urandom_range(3);
    for (int c = 0; c < lim; c++) begin
      case (style)
        0: pct = $urandom_range(100, 75);
        1: pct = $urandom_range(35);
        2: pct = int'(sb.threshold) - 4 + $urandom_range(8);
        default: pct = $urandom_range(100);
      endcase
      if (pct > 100) pct = 100;
      if (pct < 0) pct = 0;
      send_sample(3'(c), pct);
    end
  endtask

  task automatic send_noise();
    logic [1:0] f;
    logic [2:0] core;
    logic [63:0] w, i;
    case ($urandom_range(9))
      0, 1: f = FUNC_SUSPEND;
      2, 3: f = FUNC_RESUME;
      4: f = FUNC_UNUSED;
      default: f = FUNC_SAMPLE;
    endcase
    core = 3'($urandom_range(7));
    w = {$urandom, $urandom};
    i = {$urandom, $urandom};
    if (f == FUNC_SAMPLE) begin
      run_wall[core] = w;
      run_idle[core] = i;
    end
    send_request(f, core, w, i);
  endtask

  task automatic run_directed();
    send_request(FUNC_SAMPLE, 3'd0, 64'd0, 64'd0);                // zero wall delta
    send_request(FUNC_SAMPLE, 3'd1, 64'd100, 64'd0);              // full load
    send_request(FUNC_SAMPLE, 3'd2, 64'hFFFF_FFFF, 64'd0);        // widest delta
    send_request(FUNC_SAMPLE, 3'd3, 64'd1000, 64'd2000);          // idle above wall
    send_request(FUNC_SAMPLE, 3'd7, '1, 64'hFFFF_FFFF_0000_0000); // last core
    send_request(FUNC_SAMPLE, 3'd0, 64'd1000, 64'd0);
    send_request(FUNC_SAMPLE, 3'd0, 64'd3000, 64'd0);             // brings core 1 up
    send_request(FUNC_SAMPLE, 3'd1, 64'd5000, 64'd100);           // offline at tick start
    send_request(FUNC_SUSPEND, 3'd0, '0, '0);
    send_request(FUNC_SAMPLE, 3'd0, 64'd4000, 64'd500);
    send_request(FUNC_SAMPLE, 3'd5, 64'd9000, 64'd0);             // taken down by suspend
    send_request(FUNC_RESUME, 3'd0, '0, '0);
    send_request(FUNC_UNUSED, 3'd7, '1, '1);
    idle_input();
    drain();
    write_reg(REG_ENDURANCE, 32'(LEVEL_TWO));
    apb_release();
    send_request(FUNC_SAMPLE, 3'd3, 64'd7000, 64'd0);             // beyond core limit
    send_request(FUNC_SAMPLE, 3'd1, 64'd8000, 64'd100);
    send_request(FUNC_SUSPEND, 3'd0, '0, '0);
    send_request(FUNC_RESUME, 3'd0, '0, '0);
    idle_input();
    drain();
    write_reg(REG_SUSPEND, 32'(SUSPEND_MAX));
    apb_release();
    send_request(FUNC_SUSPEND, 3'd0, '0, '0);                     // clamped to two
    send_request(FUNC_RESUME, 3'd0, '0, '0);
  endtask

  int thr_set[8] = '{65, 11, 127, 100, 50, 30, 80, 11};
  int susp_set[8] = '{2, 1, 8, 8, 5, 3, 8, 4};
  logic [1:0] lvl_set[8] = '{LEVEL_FULL, LEVEL_FULL, LEVEL_FOUR, LEVEL_TWO,
                             LEVEL_FOUR, LEVEL_TWO, LEVEL_FULL, LEVEL_FOUR};

  initial begin
    int start;
    bit paused;
    for (int c = 0; c < 8; c++) begin
      run_wall[c] = {$urandom, $urandom};
      run_idle[c] = run_wall[c] - 64'($urandom_range(100000));
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int p = 0; p < 8; p++) begin
      idle_input();
      drain();
      configure(thr_set[p], susp_set[p], lvl_set[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      // back pressure: receiver holds off while requests keep coming
      if (p == 2) hold_requests++;
      start = items_sent;
      paused = 1'b0;
      while (items_sent - start < PHASE_ITEMS) begin
        if (p == 5 && !paused && items_sent - start >= PHASE_ITEMS / 2) begin
          idle_input();
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(9) < 7) run_tick();
        else send_noise();
      end
    end
    idle_input();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
